// ===== design/cascf_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the status frame checker.
package cascf_pkg;

  localparam int unsigned IdW       = 11;
  localparam int unsigned LenW      = 4;
  localparam int unsigned WordW     = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned NumBytes  = 7;

  localparam int unsigned MidDepthDefault = 2;
  localparam int unsigned OutDepthDefault = 2;

  localparam logic [IdW-1:0]   MessageIdReset       = 11'd0;
  localparam logic [ByteW-1:0] ExpectedVersionReset = 8'd16;
  localparam logic [ByteW-1:0] StallThresholdReset  = 8'd3;

  localparam logic [LenW-1:0]  MinLength  = 4'd8;
  localparam logic [ByteW-1:0] CrcPoly    = 8'h1D;
  localparam logic [ByteW-1:0] CrcInit    = 8'hFF;
  localparam logic [ByteW-1:0] CrcXorOut  = 8'hFF;
  localparam logic [ByteW-1:0] RepeatMax  = 8'hFF;

  localparam logic [1:0] ReservedInputMode   = 2'd3;
  localparam logic [2:0] ReservedPowerMode   = 3'd7;
  localparam logic [1:0] ReservedHealthState = 2'd3;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StOtherId = 2'd1,
    StShort   = 2'd2,
    StBadCrc  = 2'd3
  } frame_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMessageId       = 2'd0,
    CfgExpectedVersion = 2'd1,
    CfgStallThreshold  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    frame_status_e                    status;
    logic [NumBytes-1:0][ByteW-1:0]   bytes;
  } class_item_t;

  typedef struct packed {
    frame_status_e frame_status;
    logic [7:0]    iface_rev;
    logic [1:0]    src_mode;
    logic [2:0]    supply_mode;
    logic [1:0]    health_code;
    logic          remote_fault;
    logic [7:0]    dtc_total;
    logic [7:0]    domain_flags;
    logic [15:0]   fault_code;
    logic [7:0]    alive_value;
    logic          alive_stuck;
    logic          frame_usable;
  } result_t;

  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < ByteW; b++) begin
      c = c[ByteW-1] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== design/crc_alive_status_frame_checker_core.sv =====
// Top level of the status frame checker: configuration registers, stages and queues.
//
//   Channel   Handshake              Beat
//   frame     push / full            can_id, frame_length, data_low, data_high
//   result    empty / pop            frame_status and the unpacked status fields
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One frame is accepted per cycle unless full; its result then crosses both queues.
// The front classifies a frame combinationally in the accept cycle, CRC-8 included.
// The back updates the alive state as an OK entry moves into the result queue.
// Reset clears the queues and the alive state and loads the register defaults.
// Either side may stall; each queue holds the beats the other side cannot take yet.
module crc_alive_status_frame_checker_core #(
  parameter int unsigned MidDepth = cascf_pkg::MidDepthDefault,
  parameter int unsigned OutDepth = cascf_pkg::OutDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [cascf_pkg::IdW-1:0]       can_id_i,
  input  logic [cascf_pkg::LenW-1:0]      frame_length_i,
  input  logic [cascf_pkg::WordW-1:0]     data_low_i,
  input  logic [cascf_pkg::WordW-1:0]     data_high_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      frame_status_o,
  output logic [7:0]                      iface_rev_o,
  output logic [1:0]                      src_mode_o,
  output logic [2:0]                      supply_mode_o,
  output logic [1:0]                      health_code_o,
  output logic                            remote_fault_o,
  output logic [7:0]                      dtc_total_o,
  output logic [7:0]                      domain_flags_o,
  output logic [15:0]                     fault_code_o,
  output logic [7:0]                      alive_value_o,
  output logic                            alive_stuck_o,
  output logic                            frame_usable_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cascf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cascf_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cascf_pkg::*;

  localparam int unsigned MidW = $bits(class_item_t);
  localparam int unsigned OutW = $bits(result_t);

  logic [IdW-1:0]   message_id_q;
  logic [ByteW-1:0] expected_version_q, stall_threshold_q;

  class_item_t      front_item, mid_item;
  logic [MidW-1:0]  mid_data;
  logic             mid_empty, mid_pop;
  result_t          back_res, out_res;
  logic [OutW-1:0]  out_data;
  logic             out_full, out_push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      message_id_q       <= MessageIdReset;
      expected_version_q <= ExpectedVersionReset;
      stall_threshold_q  <= StallThresholdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CfgMessageId:       message_id_q       <= cfg_data_i;
        CfgExpectedVersion: expected_version_q <= cfg_data_i[ByteW-1:0];
        CfgStallThreshold:  stall_threshold_q  <= cfg_data_i[ByteW-1:0];
        default: begin
        end
      endcase
    end
  end

  cascf_front u_front (
    .can_id_i       (can_id_i),
    .frame_length_i (frame_length_i),
    .data_low_i     (data_low_i),
    .data_high_i    (data_high_i),
    .message_id_i   (message_id_q),
    .item_o         (front_item)
  );

  cascf_fifo #(
    .Depth (MidDepth),
    .Width (MidW)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign mid_item = class_item_t'(mid_data);

  cascf_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_i             (mid_item),
    .item_valid_i       (!mid_empty),
    .item_pop_o         (mid_pop),
    .res_ready_i        (!out_full),
    .res_push_o         (out_push),
    .result_o           (back_res),
    .expected_version_i (expected_version_q),
    .stall_threshold_i  (stall_threshold_q)
  );

  cascf_fifo #(
    .Depth (OutDepth),
    .Width (OutW)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign out_res         = result_t'(out_data);
  assign frame_status_o  = out_res.frame_status;
  assign iface_rev_o     = out_res.iface_rev;
  assign src_mode_o      = out_res.src_mode;
  assign supply_mode_o   = out_res.supply_mode;
  assign health_code_o   = out_res.health_code;
  assign remote_fault_o  = out_res.remote_fault;
  assign dtc_total_o     = out_res.dtc_total;
  assign domain_flags_o  = out_res.domain_flags;
  assign fault_code_o    = out_res.fault_code;
  assign alive_value_o   = out_res.alive_value;
  assign alive_stuck_o   = out_res.alive_stuck;
  assign frame_usable_o  = out_res.frame_usable;

endmodule

// ===== design/cascf_front.sv =====
// Front stage: identifier, length and CRC-8 classification of a received frame.
module cascf_front (
  input  logic [cascf_pkg::IdW-1:0]   can_id_i,
  input  logic [cascf_pkg::LenW-1:0]  frame_length_i,
  input  logic [cascf_pkg::WordW-1:0] data_low_i,
  input  logic [cascf_pkg::WordW-1:0] data_high_i,
  input  logic [cascf_pkg::IdW-1:0]   message_id_i,
  output cascf_pkg::class_item_t      item_o
);
  import cascf_pkg::*;

  logic [NumBytes-1:0][ByteW-1:0] bytes;
  logic [ByteW-1:0]               crc_byte;
  logic [ByteW-1:0]               crc;

  assign bytes    = {data_high_i[23:0], data_low_i};
  assign crc_byte = data_high_i[31:24];

  always_comb begin
    crc = CrcInit;
    crc = crc8_byte(crc, message_id_i[7:0]);
    crc = crc8_byte(crc, {5'd0, message_id_i[10:8]});
    for (int i = 0; i < NumBytes; i++) begin
      crc = crc8_byte(crc, bytes[i]);
    end
    crc = crc ^ CrcXorOut;
  end

  always_comb begin
    item_o.bytes = bytes;
    if (can_id_i != message_id_i) begin
      item_o.status = StOtherId;
    end else if (frame_length_i < MinLength) begin
      item_o.status = StShort;
    end else if (crc != crc_byte) begin
      item_o.status = StBadCrc;
    end else begin
      item_o.status = StOk;
    end
  end

endmodule

// ===== design/cascf_fifo.sv =====
// Small register queue used between the stages and in front of the result ports.
module cascf_fifo #(
  parameter int unsigned Depth = cascf_pkg::MidDepthDefault,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  import cascf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue holds more beats than its depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on a lone push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue has unequal pointers");
`endif

endmodule

// ===== design/cascf_back.sv =====
// Back stage: alive counter supervision and unpacking of the status fields.
module cascf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cascf_pkg::class_item_t       item_i,
  input  logic                         item_valid_i,
  output logic                         item_pop_o,
  input  logic                         res_ready_i,
  output logic                         res_push_o,
  output cascf_pkg::result_t           result_o,
  input  logic [cascf_pkg::ByteW-1:0]  expected_version_i,
  input  logic [cascf_pkg::ByteW-1:0]  stall_threshold_i
);
  import cascf_pkg::*;

  logic             seen_q, seen_d;
  logic [ByteW-1:0] prev_q, prev_d;
  logic [ByteW-1:0] rep_q, rep_d;
  logic             take, ok, same;
  logic [ByteW-1:0] rep_next;
  logic [ByteW-1:0] b1;

  assign take       = item_valid_i && res_ready_i;
  assign item_pop_o = take;
  assign res_push_o = take;
  assign ok         = (item_i.status == StOk);
  assign same       = seen_q && (item_i.bytes[6] == prev_q);
  assign b1         = item_i.bytes[1];

  always_comb begin
    if (!same) begin
      rep_next = '0;
    end else if (rep_q == RepeatMax) begin
      rep_next = rep_q;
    end else begin
      rep_next = rep_q + 8'd1;
    end
  end

  always_comb begin
    seen_d = seen_q;
    prev_d = prev_q;
    rep_d  = rep_q;
    if (take && ok) begin
      seen_d = 1'b1;
      prev_d = item_i.bytes[6];
      rep_d  = rep_next;
    end
  end

  always_comb begin
    result_o              = '0;
    result_o.frame_status = item_i.status;
    if (ok) begin
      result_o.iface_rev     = item_i.bytes[0];
      result_o.src_mode      = b1[1:0];
      result_o.supply_mode   = b1[4:2];
      result_o.health_code   = b1[6:5];
      result_o.remote_fault  = b1[7];
      result_o.dtc_total     = item_i.bytes[2];
      result_o.domain_flags  = item_i.bytes[3];
      result_o.fault_code    = {item_i.bytes[5], item_i.bytes[4]};
      result_o.alive_value   = item_i.bytes[6];
      result_o.alive_stuck   = (rep_next >= stall_threshold_i);
      result_o.frame_usable  = (item_i.bytes[0] == expected_version_i) &&
                               (b1[1:0] != ReservedInputMode) &&
                               (b1[4:2] != ReservedPowerMode) &&
                               (b1[6:5] != ReservedHealthState);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      prev_q <= '0;
      rep_q  <= '0;
    end else begin
      seen_q <= seen_d;
      prev_q <= prev_d;
      rep_q  <= rep_d;
    end
  end

`ifndef ASSERT_OFF
  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !ok) |=> ($stable(seen_q) && $stable(prev_q) && $stable(rep_q)))
    else $error("rejected frame changed the alive state");

  a_reject_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && result_o.frame_status != StOk) |->
      (result_o.iface_rev == '0 && !result_o.alive_stuck &&
       !result_o.frame_usable))
    else $error("rejected frame carries status fields");

  a_accept_sets_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && ok) |=> (seen_q && prev_q == $past(item_i.bytes[6])))
    else $error("accepted frame did not record its alive value");

  a_repeat_needs_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_q != '0) |-> seen_q)
    else $error("repeat count is set before any frame was accepted");
`endif

endmodule

// ===== tb/sv/status_frame_result_checker.sv =====
`timescale 1ns / 1ps
// Watches the frame, result and register channels, predicts each status beat and compares it.
module status_frame_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           full,
  input  logic [cascf_pkg::IdW-1:0]      can_id_i,
  input  logic [cascf_pkg::LenW-1:0]     frame_length_i,
  input  logic [cascf_pkg::WordW-1:0]    data_low_i,
  input  logic [cascf_pkg::WordW-1:0]    data_high_i,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [1:0]                     frame_status_i,
  input  logic [7:0]                     iface_rev_i,
  input  logic [1:0]                     src_mode_i,
  input  logic [2:0]                     supply_mode_i,
  input  logic [1:0]                     health_code_i,
  input  logic                           remote_fault_i,
  input  logic [7:0]                     dtc_total_i,
  input  logic [7:0]                     domain_flags_i,
  input  logic [15:0]                    fault_code_i,
  input  logic [7:0]                     alive_value_i,
  input  logic                           alive_stuck_i,
  input  logic                           frame_usable_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [cascf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cascf_pkg::CfgDataW-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             outstanding_o
);
  import cascf_pkg::*;

  result_t          pending_status[$];
  logic [IdW-1:0]   status_id_r;
  logic [ByteW-1:0] version_r;
  logic [ByteW-1:0] threshold_r;
  logic             alive_seen_r;
  logic [ByteW-1:0] last_alive_r;
  logic [ByteW-1:0] repeats_r;

  // Classifies one frame and, when it is accepted, advances the alive supervision.
  function automatic result_t predict_status(input logic [IdW-1:0] id,
                                             input logic [LenW-1:0] len,
                                             input logic [WordW-1:0] lo,
                                             input logic [WordW-1:0] hi);
    result_t                r;
    logic [7:0][ByteW-1:0]  b;
    logic [8:0][ByteW-1:0]  crc_in;
    logic [ByteW-1:0]       crc;
    r = '0;
    b = {hi, lo};
    crc_in = {b[6:0], 5'b0, status_id_r};
    crc = CrcInit;
    for (int i = 0; i < 9; i++) begin
      crc = crc ^ crc_in[i];
      for (int k = 0; k < 8; k++) begin
        crc = crc[7] ? ((crc << 1) ^ CrcPoly) : (crc << 1);
      end
    end
    crc = crc ^ CrcXorOut;
    if (id != status_id_r) begin
      r.frame_status = StOtherId;
    end else if (len < MinLength) begin
      r.frame_status = StShort;
    end else if (crc != b[7]) begin
      r.frame_status = StBadCrc;
    end else begin
      r.frame_status = StOk;
    end
    if (r.frame_status == StOk) begin
      if (alive_seen_r && b[6] == last_alive_r) begin
        if (repeats_r != RepeatMax) begin
          repeats_r = repeats_r + 1'b1;
        end
      end else begin
        repeats_r = '0;
      end
      alive_seen_r = 1'b1;
      last_alive_r = b[6];
      r.iface_rev = b[0];
      {r.remote_fault, r.health_code, r.supply_mode, r.src_mode} = b[1];
      r.dtc_total = b[2];
      r.domain_flags = b[3];
      r.fault_code = {b[5], b[4]};
      r.alive_value = b[6];
      r.alive_stuck = (repeats_r >= threshold_r);
      r.frame_usable = (b[0] == version_r) && (r.src_mode != ReservedInputMode) &&
                       (r.supply_mode != ReservedPowerMode) &&
                       (r.health_code != ReservedHealthState);
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      status_id_r = MessageIdReset;
      version_r = ExpectedVersionReset;
      threshold_r = StallThresholdReset;
      alive_seen_r = 1'b0;
      last_alive_r = '0;
      repeats_r = '0;
      pending_status.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_e'(cfg_index_i))
          CfgMessageId:       status_id_r = cfg_data_i;
          CfgExpectedVersion: version_r = cfg_data_i[ByteW-1:0];
          CfgStallThreshold:  threshold_r = cfg_data_i[ByteW-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        pending_status.push_back(predict_status(can_id_i, frame_length_i, data_low_i,
                                                data_high_i));
      end
      if (pop && !empty) begin
        if (pending_status.size() == 0) begin
          $display("%0t: result beat with no frame pending, expected none, actual status %0h",
                   $time, frame_status_i);
          fail_count_o++;
        end else begin
          want = pending_status.pop_front();
          compare_field("frame_status", 16'(want.frame_status), 16'(frame_status_i));
          compare_field("iface_rev", 16'(want.iface_rev), 16'(iface_rev_i));
          compare_field("src_mode", 16'(want.src_mode), 16'(src_mode_i));
          compare_field("supply_mode", 16'(want.supply_mode), 16'(supply_mode_i));
          compare_field("health_code", 16'(want.health_code), 16'(health_code_i));
          compare_field("remote_fault", 16'(want.remote_fault), 16'(remote_fault_i));
          compare_field("dtc_total", 16'(want.dtc_total), 16'(dtc_total_i));
          compare_field("domain_flags", 16'(want.domain_flags), 16'(domain_flags_i));
          compare_field("fault_code", want.fault_code, fault_code_i);
          compare_field("alive_value", 16'(want.alive_value), 16'(alive_value_i));
          compare_field("alive_stuck", 16'(want.alive_stuck), 16'(alive_stuck_i));
          compare_field("frame_usable", 16'(want.frame_usable), 16'(frame_usable_i));
        end
      end
    end
    outstanding_o = pending_status.size();
  end

endmodule

// ===== tb/sv/crc_alive_status_frame_checker_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the status frame checker: clock, reset, frame and result traffic, verdict.
module crc_alive_status_frame_checker_core_test;
  import cascf_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned HoldCycles = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [IdW-1:0]      can_id_i = '0;
  logic [LenW-1:0]     frame_length_i = '0;
  logic [WordW-1:0]    data_low_i = '0;
  logic [WordW-1:0]    data_high_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [1:0]          frame_status_o;
  logic [7:0]          iface_rev_o;
  logic [1:0]          src_mode_o;
  logic [2:0]          supply_mode_o;
  logic [1:0]          health_code_o;
  logic                remote_fault_o;
  logic [7:0]          dtc_total_o;
  logic [7:0]          domain_flags_o;
  logic [15:0]         fault_code_o;
  logic [7:0]          alive_value_o;
  logic                alive_stuck_o;
  logic                frame_usable_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int               fail_count;
  int               outstanding;
  bit               idle_on = 1'b1;
  bit               hold_results = 1'b0;
  event             start_hold;
  logic [IdW-1:0]   frame_id;
  logic [ByteW-1:0] version_sel;
  logic [ByteW-1:0] alive_cur;

  crc_alive_status_frame_checker_core dut (
    .clk_i, .rst_ni, .push, .full, .can_id_i, .frame_length_i, .data_low_i, .data_high_i,
    .empty, .pop, .frame_status_o, .iface_rev_o, .src_mode_o, .supply_mode_o,
    .health_code_o, .remote_fault_o, .dtc_total_o, .domain_flags_o,
    .fault_code_o, .alive_value_o, .alive_stuck_o, .frame_usable_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  status_frame_result_checker frame_check (
    .clk_i, .rst_ni, .push, .full, .can_id_i, .frame_length_i, .data_low_i, .data_high_i,
    .empty, .pop,
    .frame_status_i(frame_status_o),
    .iface_rev_i(iface_rev_o),
    .src_mode_i(src_mode_o),
    .supply_mode_i(supply_mode_o),
    .health_code_i(health_code_o),
    .remote_fault_i(remote_fault_o),
    .dtc_total_i(dtc_total_o),
    .domain_flags_i(domain_flags_o),
    .fault_code_i(fault_code_o),
    .alive_value_i(alive_value_o),
    .alive_stuck_i(alive_stuck_o),
    .frame_usable_i(frame_usable_o),
    .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .fail_count_o(fail_count),
    .outstanding_o(outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    int gap;
    gap = 0;
    forever begin
      @(negedge clk_i);
      if (hold_results || gap > 0) begin
        pop <= 1'b0;
        if (gap > 0) begin
          gap--;
        end
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        gap = $urandom_range(0, 10);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // The result side holds off long enough for the block to fill and refuse frames.
  initial begin
    @(start_hold);
    hold_results = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_results = 1'b0;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [ByteW-1:0] frame_crc(input logic [IdW-1:0] id,
                                                 input logic [WordW-1:0] lo,
                                                 input logic [23:0] hi_rest);
    logic [8:0][ByteW-1:0] seq;
    logic [ByteW-1:0]      c;
    seq = {hi_rest, lo, 5'b0, id};
    c = CrcInit;
    for (int i = 0; i < 9; i++) begin
      c = crc8_byte(c, seq[i]);
    end
    return c ^ CrcXorOut;
  endfunction

  task automatic send_frame(input logic [IdW-1:0] id, input logic [LenW-1:0] len,
                            input logic [WordW-1:0] lo, input logic [WordW-1:0] hi);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    push <= 1'b1;
    can_id_i <= id;
    frame_length_i <= len;
    data_low_i <= lo;
    data_high_i <= hi;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic send_status(input logic [LenW-1:0] len, input logic [WordW-1:0] lo,
                             input logic [23:0] hi_rest, input bit crc_ok);
    logic [ByteW-1:0] crc;
    crc = frame_crc(frame_id, lo, hi_rest);
    if (!crc_ok) begin
      crc = crc ^ ByteW'($urandom_range(1, 255));
    end
    send_frame(frame_id, len, lo, {crc, hi_rest});
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [IdW-1:0] id, input logic [ByteW-1:0] version,
                           input logic [ByteW-1:0] threshold);
    drain_results();
    write_reg(CfgMessageId, id);
    write_reg(CfgExpectedVersion, {3'($urandom()), version});
    write_reg(CfgStallThreshold, {3'($urandom()), threshold});
    write_reg(CfgUnmapped, CfgDataW'($urandom()));
    cfg_valid_i <= 1'b0;
    frame_id = id;
    version_sel = version;
  endtask

  // Mostly well-formed frames, so the alive supervision sees long runs of repeats.
  task automatic send_random_frame(output bit useful);
    int               kind;
    logic [WordW-1:0] lo;
    logic [23:0]      hi_rest;
    logic [IdW-1:0]   id;
    kind = $urandom_range(0, 19);
    lo = $urandom();
    hi_rest = 24'($urandom());
    useful = 1'b1;
    if (kind < 14) begin
      case ($urandom_range(0, 3))
        0, 1: ;
        2: alive_cur = alive_cur + 1'b1;
        default: alive_cur = ByteW'($urandom());
      endcase
      if ($urandom_range(0, 3) != 0) begin
        lo[7:0] = version_sel;
      end
      hi_rest[23:16] = alive_cur;
      send_status(($urandom_range(0, 5) == 0) ? LenW'($urandom_range(9, 15)) : MinLength,
                  lo, hi_rest, 1'b1);
    end else if (kind < 16) begin
      send_status(LenW'($urandom_range(8, 15)), lo, hi_rest, 1'b0);
    end else if (kind < 18) begin
      send_status(LenW'($urandom_range(0, 7)), lo, hi_rest, 1'b1);
    end else begin
      do id = IdW'($urandom()); while (id == frame_id);
      useful = 1'b0;
      send_frame(id, LenW'($urandom()), lo, $urandom());
    end
  endtask

  task automatic run_random(input int target);
    int count;
    bit useful;
    count = 0;
    while (count < target) begin
      send_random_frame(useful);
      if (useful) begin
        count++;
      end
    end
  endtask

  initial begin
    logic [WordW-1:0] lo;
    logic [23:0]      hi_rest;
    frame_id = MessageIdReset;
    version_sel = ExpectedVersionReset;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Register defaults: the fourth identical alive value reaches the stall threshold.
    repeat (4) send_status(MinLength, {16'h1234, 8'h00, version_sel}, 24'h05BEEF, 1'b1);
    send_frame(11'h7FF, 4'd0, '0, '0);
    send_status(4'd7, {16'h1234, 8'h00, version_sel}, 24'h06BEEF, 1'b1);
    send_status(4'd15, {16'hA55A, 8'hFF, version_sel}, 24'h07C0DE, 1'b1);
    send_status(MinLength, {16'h1234, 8'h00, version_sel}, 24'h08BEEF, 1'b0);
    send_status(MinLength, {16'h0102, 8'h03, version_sel}, 24'h090304, 1'b1);
    send_status(MinLength, {16'h0102, 8'h1C, version_sel}, 24'h0A0304, 1'b1);
    send_status(MinLength, {16'h0102, 8'h60, version_sel}, 24'h0B0304, 1'b1);
    send_status(MinLength, {16'h0102, 8'h80, version_sel}, 24'h0C0304, 1'b1);
    send_status(MinLength, '0, '0, 1'b1);
    send_status(MinLength, '1, '1, 1'b1);

    configure(11'h7FF, 8'hFF, 8'd0);
    send_status(MinLength, {16'h5566, 8'h00, version_sel}, 24'h201122, 1'b1);
    send_frame(11'h000, MinLength, '0, '0);
    send_status(4'd0, {16'h5566, 8'h00, version_sel}, 24'h211122, 1'b1);
    send_status(MinLength, {16'h5566, 8'h45, version_sel}, 24'h221122, 1'b1);

    alive_cur = ByteW'($urandom());
    configure(IdW'($urandom()), ByteW'($urandom()), 8'd2);
    -> start_hold;
    run_random(60);

    configure(11'h000, 8'h00, 8'd1);
    run_random(60);

    // Enough repeats of one alive value to drive the repeat count into saturation.
    configure(11'h7FF, ByteW'($urandom()), RepeatMax);
    alive_cur = ByteW'($urandom());
    repeat (300) begin
      lo = $urandom();
      hi_rest = {alive_cur, 16'($urandom())};
      send_status(MinLength, lo, hi_rest, $urandom_range(0, 9) != 0);
    end

    idle_on = 1'b0;
    configure(IdW'($urandom()), ByteW'($urandom()), ByteW'($urandom_range(0, 5)));
    run_random(60);

    drain_results();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
